/* src/thws_pkg.sv */
// shared constants and types for the hit window statistics block
// no dependencies

package thws_pkg;

   // field widths
   localparam int TOF_W    = 20;
   localparam int PULSES_W = 8;
   localparam int OUT_CNT_W = 13;
   localparam int Q8_W     = 20;

   // pulse boundary threshold in ticks
   localparam logic [TOF_W-1:0] DROP_LIMIT = 20'd10000;

   // saturation value and unit value of the q.8 results
   localparam logic [Q8_W-1:0] Q8_MAX  = 20'hFFFFF;
   localparam logic [Q8_W-1:0] Q8_ONE  = 20'd256;

   // register reset values
   localparam logic [TOF_W-1:0]    WINDOW_RESET = 20'd4000;
   localparam logic [PULSES_W-1:0] PULSES_RESET = 8'd1;

   // register indexes of the write port
   localparam int CSR_AW = 1;
   typedef enum logic [CSR_AW-1:0] {
      CSR_WINDOW_TICKS  = 1'b0,
      CSR_PULSES_WANTED = 1'b1
   } csr_index_type;

endpackage

/* src/tof_hit_window_statistics.sv */
// Hits load at one transfer per cycle into the hit store; the item marked last
// starts the analysis, during which no hit is taken. Every hit store or
// boundary store access of the analysis goes through a registered read port,
// a single one per store, so each access takes an address state and a data state.
// The statistics then use shift-add multiplies, three divisions and two square
// roots. The fallback path is one division. A result may wait in the output
// register while the next batch loads. There is no clearing pass after reset.
// depends on thws_pkg, thws_divider, thws_isqrt

module tof_hit_window_statistics #(
   parameter int HIT_DEPTH      = 4096,
   parameter int BOUNDARY_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // hit channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [thws_pkg::TOF_W-1:0]     req_hit_tof,
   input  logic                           req_last_hit,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [thws_pkg::OUT_CNT_W-1:0] rsp_pulses_analyzed,
   output logic [thws_pkg::OUT_CNT_W-1:0] rsp_total_hits,
   output logic [thws_pkg::Q8_W-1:0]      rsp_mean_q8,
   output logic [thws_pkg::Q8_W-1:0]      rsp_deviation_q8,
   output logic [thws_pkg::OUT_CNT_W-1:0] rsp_overlap_hits,
   output logic                           rsp_store_overflow,
   // register write port
   input  logic                           csr_we,
   input  logic [thws_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [thws_pkg::TOF_W-1:0]     csr_wdata
);

   localparam int TW  = thws_pkg::TOF_W;
   localparam int PW  = thws_pkg::PULSES_W;
   localparam int OW  = thws_pkg::OUT_CNT_W;
   localparam int QW8 = thws_pkg::Q8_W;
   localparam int CW  = $clog2(HIT_DEPTH + 1);
   localparam int HW  = $clog2(HIT_DEPTH);
   localparam int BW  = $clog2(BOUNDARY_DEPTH);
   localparam int SW  = 2 * CW;
   localparam int QW  = 3 * CW;
   localparam int AW  = 4 * CW;
   localparam int NW  = AW + 16;
   localparam int VW  = 2 * CW;
   localparam int RW  = 2 * CW + 16;
   localparam int RTW = RW / 2;

   typedef enum logic [4:0] {
      S_LOAD, S_DECIDE, S_FB_DIV,
      S_PSTART, S_PSTART_D, S_PEND, S_PEND_D,
      S_WIN, S_WIN_D, S_CNT, S_CNT_D, S_ACC, S_ADV, S_ADV_D, S_STEP,
      S_STATS, S_MUL_NQ, S_MUL_SS,
      S_DEV_DIV, S_DEV_SQRT, S_OV_DIV, S_OV_SQRT, S_MEAN_DIV, S_OUT
   } state_type;

   // registers
   state_type       state_ff, state_in;
   logic [TW-1:0]   window_ff, window_in;
   logic [PW-1:0]   pulses_ff, pulses_in;
   logic [CW-1:0]   hc_ff, hc_in;
   logic [CW-1:0]   bc_ff, bc_in;
   logic [TW-1:0]   prev_ff, prev_in;
   logic            ovf_ff, ovf_in;
   logic [CW-1:0]   sc_ff, sc_in;
   logic [SW-1:0]   ssum_ff, ssum_in;
   logic [QW-1:0]   ssq_ff, ssq_in;
   logic [PW-1:0]   np_ff, np_in;
   logic [PW-1:0]   p_ff, p_in;
   logic [CW-1:0]   w_ff, w_in;
   logic [CW-1:0]   c_ff, c_in;
   logic [CW-1:0]   end_ff, end_in;
   logic [CW-1:0]   before_ff, before_in;
   logic [TW:0]     we_ff, we_in;
   logic [TW:0]     target_ff, target_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [AW-1:0]   acc_ff, acc_in;
   logic [AW-1:0]   mcand_ff, mcand_in;
   logic [SW-1:0]   mplier_ff, mplier_in;
   logic [VW-1:0]   nn_ff, nn_in;
   logic [OW-1:0]   po_ff, po_in;
   logic [QW8-1:0]  mean_ff, mean_in;
   logic [QW8-1:0]  dev_ff, dev_in;
   logic [OW-1:0]   ov_ff, ov_in;
   logic            r9nz_ff, r9nz_in;
   logic            div_start_ff, div_start_in;
   logic [NW-1:0]   div_num_ff, div_num_in;
   logic [VW-1:0]   div_den_ff, div_den_in;
   logic            sq_start_ff, sq_start_in;
   logic [RW-1:0]   sq_rad_ff, sq_rad_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]   rsp_po_ff, rsp_po_in;
   logic [OW-1:0]   rsp_hits_ff, rsp_hits_in;
   logic [QW8-1:0]  rsp_mean_ff, rsp_mean_in;
   logic [QW8-1:0]  rsp_dev_ff, rsp_dev_in;
   logic [OW-1:0]   rsp_ov_ff, rsp_ov_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   // memories
   logic [TW-1:0]   hit_mem [HIT_DEPTH];
   logic [HW-1:0]   bnd_mem [BOUNDARY_DEPTH];
   logic [TW-1:0]   hit_rdata_ff;
   logic [HW-1:0]   bnd_rdata_ff;
   logic            hit_we;
   logic [HW-1:0]   hit_waddr;
   logic [HW-1:0]   hit_raddr;
   logic            bnd_we;
   logic [BW-1:0]   bnd_waddr;
   logic [HW-1:0]   bnd_wdata;
   logic [BW-1:0]   bnd_raddr;

   // arithmetic units
   logic            div_done;
   logic [NW-1:0]   div_quot;
   logic [VW-1:0]   div_rem;
   logic            sq_done;
   logic [RTW-1:0]  sq_root;
   logic            sq_rem_nz;

   // helpers
   logic            accept;
   logic            is_boundary;
   logic [CW:0]     w_plus1;
   logic [PW-1:0]   np_calc;
   logic [QW8-1:0]  mean_sat;
   logic [VW-1:0]   n_sq;

   assign accept      = req_valid && req_ready;
   assign req_ready   = state_ff == S_LOAD;
   assign is_boundary = (hc_ff != '0) && (req_hit_tof < prev_ff)
                        && ((prev_ff - req_hit_tof) > thws_pkg::DROP_LIMIT);
   assign w_plus1     = {1'b0, w_ff} + {{CW{1'b0}}, 1'b1};
   assign n_sq        = VW'(n_ff) * VW'(n_ff);
   assign mean_sat    = (div_quot > NW'(thws_pkg::Q8_MAX)) ? thws_pkg::Q8_MAX
                                                           : QW8'(div_quot);

   // pulses to scan, limited so that every pulse end is stored
   always_comb begin
      np_calc = pulses_ff;
      if (int'(pulses_ff) >= BOUNDARY_DEPTH) begin
         np_calc = (int'(bc_ff) == BOUNDARY_DEPTH) ? PW'(BOUNDARY_DEPTH)
                                                   : PW'(BOUNDARY_DEPTH - 1);
      end
   end

   // hit store write during load
   assign hit_we    = accept && (int'(hc_ff) < HIT_DEPTH);
   assign hit_waddr = hc_ff[HW-1:0];
   assign bnd_we    = hit_we && is_boundary && (int'(bc_ff) < BOUNDARY_DEPTH);
   assign bnd_waddr = BW'(bc_ff);
   assign bnd_wdata = hc_ff[HW-1:0];

   // read address selection
   always_comb begin
      unique case (state_ff)
         S_CNT:   hit_raddr = c_ff[HW-1:0];
         default: hit_raddr = w_ff[HW-1:0];
      endcase
      unique case (state_ff)
         S_PEND:  bnd_raddr = BW'(p_ff + 1'b1);
         default: bnd_raddr = BW'(p_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (hit_we) begin
         hit_mem[hit_waddr] <= req_hit_tof;
      end
      hit_rdata_ff <= hit_mem[hit_raddr];
   end

   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bnd_mem[bnd_waddr] <= bnd_wdata;
      end
      bnd_rdata_ff <= bnd_mem[bnd_raddr];
   end

   thws_divider #(
      .NUM_W (NW),
      .DEN_W (VW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_num_ff),
      .divisor   (div_den_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   thws_isqrt #(
      .RAD_W (RW)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .start       (sq_start_ff),
      .radicand    (sq_rad_ff),
      .done        (sq_done),
      .root        (sq_root),
      .rem_nonzero (sq_rem_nz)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      pulses_in    = pulses_ff;
      hc_in        = hc_ff;
      bc_in        = bc_ff;
      prev_in      = prev_ff;
      ovf_in       = ovf_ff;
      sc_in        = sc_ff;
      ssum_in      = ssum_ff;
      ssq_in       = ssq_ff;
      np_in        = np_ff;
      p_in         = p_ff;
      w_in         = w_ff;
      c_in         = c_ff;
      end_in       = end_ff;
      before_in    = before_ff;
      we_in        = we_ff;
      target_in    = target_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      nn_in        = nn_ff;
      po_in        = po_ff;
      mean_in      = mean_ff;
      dev_in       = dev_ff;
      ov_in        = ov_ff;
      r9nz_in      = r9nz_ff;
      div_start_in = 1'b0;
      div_num_in   = div_num_ff;
      div_den_in   = div_den_ff;
      sq_start_in  = 1'b0;
      sq_rad_in    = sq_rad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_po_in    = rsp_po_ff;
      rsp_hits_in  = rsp_hits_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_dev_in   = rsp_dev_ff;
      rsp_ov_in    = rsp_ov_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // register writes
      if (csr_we) begin
         unique case (thws_pkg::csr_index_type'(csr_addr))
            thws_pkg::CSR_WINDOW_TICKS:  window_in = csr_wdata;
            thws_pkg::CSR_PULSES_WANTED: pulses_in = csr_wdata[PW-1:0];
         endcase
      end

      unique case (state_ff)
         // hit load and boundary marking
         S_LOAD: begin
            if (accept) begin
               if (hit_we) begin
                  if (is_boundary) begin
                     bc_in = bc_ff + 1'b1;
                  end
                  hc_in   = hc_ff + 1'b1;
                  prev_in = req_hit_tof;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_hit) begin
                  state_in = S_DECIDE;
               end
            end
         end
         // fallback or pulse scan
         S_DECIDE: begin
            if (int'(bc_ff) < int'(pulses_ff)) begin
               po_in        = OW'(bc_ff);
               div_num_in   = NW'({hc_ff, 8'b0});
               div_den_in   = VW'(bc_ff);
               div_start_in = 1'b1;
               state_in     = S_FB_DIV;
            end else begin
               np_in = np_calc;
               po_in = OW'(np_calc);
               p_in  = '0;
               state_in = (np_calc == '0) ? S_STATS : S_PSTART;
            end
         end
         S_FB_DIV: begin
            if (div_done) begin
               mean_in  = mean_sat;
               dev_in   = '0;
               ov_in    = '0;
               state_in = S_OUT;
            end
         end
         // pulse start: first pulse always starts at hit zero
         S_PSTART: begin
            if (p_ff == '0) begin
               w_in     = '0;
               state_in = S_PEND;
            end else begin
               state_in = S_PSTART_D;
            end
         end
         S_PSTART_D: begin
            w_in     = CW'(bnd_rdata_ff);
            state_in = S_PEND;
         end
         // pulse end: next boundary or end of batch
         S_PEND: begin
            if (int'(p_ff) + 1 < int'(bc_ff)) begin
               state_in = S_PEND_D;
            end else begin
               end_in   = hc_ff;
               state_in = S_WIN;
            end
         end
         S_PEND_D: begin
            end_in   = CW'(bnd_rdata_ff);
            state_in = S_WIN;
         end
         // next window or next pulse
         S_WIN: begin
            if (w_plus1 < {1'b0, end_ff}) begin
               state_in = S_WIN_D;
            end else if (int'(p_ff) + 1 < int'(np_ff)) begin
               p_in     = p_ff + 1'b1;
               state_in = S_PSTART;
            end else begin
               state_in = S_STATS;
            end
         end
         S_WIN_D: begin
            we_in     = {1'b0, hit_rdata_ff} + {1'b0, window_ff};
            target_in = {1'b0, hit_rdata_ff} + {3'b0, window_ff[TW-1:2]};
            c_in      = w_ff;
            n_in      = '0;
            state_in  = S_CNT;
         end
         // count hits inside the window
         S_CNT: begin
            state_in = (c_ff < end_ff) ? S_CNT_D : S_ACC;
         end
         S_CNT_D: begin
            if ({1'b0, hit_rdata_ff} <= we_ff) begin
               n_in     = n_ff + 1'b1;
               c_in     = c_ff + 1'b1;
               state_in = S_CNT;
            end else begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (n_ff != '0) begin
               sc_in   = sc_ff + 1'b1;
               ssum_in = ssum_ff + SW'(n_ff);
               ssq_in  = ssq_ff + QW'(n_sq);
            end
            before_in = w_ff;
            state_in  = S_ADV;
         end
         // advance the window start by a quarter window
         S_ADV: begin
            state_in = (w_ff < end_ff) ? S_ADV_D : S_STEP;
         end
         S_ADV_D: begin
            if ({1'b0, hit_rdata_ff} < target_ff) begin
               w_in     = w_ff + 1'b1;
               state_in = S_ADV;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (w_ff == before_ff && w_ff < end_ff) begin
               w_in = w_ff + 1'b1;
            end
            state_in = S_WIN;
         end
         // statistics: d = n*sq_sum - sum*sum by shift and add
         S_STATS: begin
            if (sc_ff == '0) begin
               mean_in  = thws_pkg::Q8_ONE;
               dev_in   = '0;
               ov_in    = '0;
               state_in = S_OUT;
            end else begin
               nn_in     = VW'(sc_ff) * VW'(sc_ff);
               acc_in    = '0;
               mcand_in  = AW'(ssq_ff);
               mplier_in = SW'(sc_ff);
               state_in  = S_MUL_NQ;
            end
         end
         S_MUL_NQ: begin
            if (mplier_ff == '0) begin
               mcand_in  = AW'(ssum_ff);
               mplier_in = ssum_ff;
               state_in  = S_MUL_SS;
            end else begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[AW-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[SW-1:1]};
            end
         end
         S_MUL_SS: begin
            if (mplier_ff == '0) begin
               div_num_in   = {acc_ff, 16'b0};
               div_den_in   = nn_ff;
               div_start_in = 1'b1;
               state_in     = S_DEV_DIV;
            end else begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff - mcand_ff;
               end
               mcand_in  = {mcand_ff[AW-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[SW-1:1]};
            end
         end
         // deviation = isqrt(d * 65536 / n^2)
         S_DEV_DIV: begin
            if (div_done) begin
               sq_rad_in   = RW'(div_quot);
               sq_start_in = 1'b1;
               state_in    = S_DEV_SQRT;
            end
         end
         S_DEV_SQRT: begin
            if (sq_done) begin
               dev_in       = QW8'(sq_root);
               div_num_in   = NW'({acc_ff, 3'b0}) + NW'(acc_ff);
               div_den_in   = nn_ff;
               div_start_in = 1'b1;
               state_in     = S_OV_DIV;
            end
         end
         // overlap = ceil(sqrt(9d / n^2)), exact from both remainders
         S_OV_DIV: begin
            if (div_done) begin
               r9nz_in     = div_rem != '0;
               sq_rad_in   = RW'(div_quot);
               sq_start_in = 1'b1;
               state_in    = S_OV_SQRT;
            end
         end
         S_OV_SQRT: begin
            if (sq_done) begin
               ov_in        = OW'(sq_root) + OW'(r9nz_ff || sq_rem_nz);
               div_num_in   = NW'({ssum_ff, 8'b0});
               div_den_in   = VW'(sc_ff);
               div_start_in = 1'b1;
               state_in     = S_MEAN_DIV;
            end
         end
         S_MEAN_DIV: begin
            if (div_done) begin
               mean_in  = mean_sat;
               state_in = S_OUT;
            end
         end
         // hand the result to the output register and clear the batch
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_po_in    = po_ff;
               rsp_hits_in  = OW'(hc_ff);
               rsp_mean_in  = mean_ff;
               rsp_dev_in   = dev_ff;
               rsp_ov_in    = ov_ff;
               rsp_ovf_in   = ovf_ff;
               hc_in        = '0;
               bc_in        = CW'(1);
               prev_in      = '0;
               ovf_in       = 1'b0;
               sc_in        = '0;
               ssum_in      = '0;
               ssq_in       = '0;
               state_in     = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         window_ff    <= thws_pkg::WINDOW_RESET;
         pulses_ff    <= thws_pkg::PULSES_RESET;
         hc_ff        <= '0;
         bc_ff        <= CW'(1);
         prev_ff      <= '0;
         ovf_ff       <= 1'b0;
         sc_ff        <= '0;
         ssum_ff      <= '0;
         ssq_ff       <= '0;
         div_start_ff <= 1'b0;
         sq_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         pulses_ff    <= pulses_in;
         hc_ff        <= hc_in;
         bc_ff        <= bc_in;
         prev_ff      <= prev_in;
         ovf_ff       <= ovf_in;
         sc_ff        <= sc_in;
         ssum_ff      <= ssum_in;
         ssq_ff       <= ssq_in;
         div_start_ff <= div_start_in;
         sq_start_ff  <= sq_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      np_ff       <= np_in;
      p_ff        <= p_in;
      w_ff        <= w_in;
      c_ff        <= c_in;
      end_ff      <= end_in;
      before_ff   <= before_in;
      we_ff       <= we_in;
      target_ff   <= target_in;
      n_ff        <= n_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      nn_ff       <= nn_in;
      po_ff       <= po_in;
      mean_ff     <= mean_in;
      dev_ff      <= dev_in;
      ov_ff       <= ov_in;
      r9nz_ff     <= r9nz_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      sq_rad_ff   <= sq_rad_in;
      rsp_po_ff   <= rsp_po_in;
      rsp_hits_ff <= rsp_hits_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_dev_ff  <= rsp_dev_in;
      rsp_ov_ff   <= rsp_ov_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pulses_analyzed = rsp_po_ff;
   assign rsp_total_hits      = rsp_hits_ff;
   assign rsp_mean_q8         = rsp_mean_ff;
   assign rsp_deviation_q8    = rsp_dev_ff;
   assign rsp_overlap_hits    = rsp_ov_ff;
   assign rsp_store_overflow  = rsp_ovf_ff;

   // boundaries never outnumber stored hits
   a_bnd_count: assert property (@(posedge clock) disable iff (reset)
      (bc_ff <= hc_ff) || (bc_ff == CW'(1)))
      else $error("boundary count exceeds hit count");

   // a fresh result leaves a cleared batch behind
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (hc_ff == '0) && (bc_ff == CW'(1)) && !ovf_ff)
      else $error("batch not cleared with result");

   // window pointers stay inside the pulse
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WIN || state_ff == S_CNT || state_ff == S_CNT_D
       || state_ff == S_ADV || state_ff == S_ADV_D || state_ff == S_STEP)
      |-> (w_ff <= end_ff) && (c_ff <= end_ff || state_ff == S_WIN))
      else $error("window pointer beyond pulse end");

   // divider finishes only where the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_FB_DIV || state_ff == S_DEV_DIV
                    || state_ff == S_OV_DIV || state_ff == S_MEAN_DIV))
      else $error("divider result outside a wait state");

endmodule

/* src/thws_divider.sv */
// restoring divider, one quotient bit per cycle
// no dependencies

module thws_divider #(
   parameter int NUM_W = 68,
   parameter int DEN_W = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // trial subtraction of the divisor from the shifted partial remainder
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* src/thws_isqrt.sv */
// integer square root, one root bit per cycle, with remainder flag
// no dependencies

module thws_isqrt #(
   parameter int RAD_W = 42
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RAD_W-1:0]   radicand,
   output logic               done,
   output logic [RAD_W/2-1:0] root,
   output logic               rem_nonzero
);

   localparam int RT_W  = RAD_W / 2;
   localparam int RM_W  = RT_W + 3;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [RM_W-1:0]  rem_ff, rem_in;
   logic [RM_W-1:0]  shifted;
   logic [RM_W-1:0]  trial;
   logic             fits;

   // bring down the next two radicand bits and try root*4+1
   assign shifted = {rem_ff[RM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial   = RM_W'({root_ff, 2'b01});
   assign fits    = shifted >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RT_W);
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         root_in = {root_ff[RT_W-2:0], fits};
         rem_in  = fits ? (shifted - trial) : shifted;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done        = done_ff;
   assign root        = root_ff;
   assign rem_nonzero = rem_ff != '0;

endmodule

/* dv/tof_hit_window_statistics_test.sv */
// testbench for tof_hit_window_statistics: hit batches with random pacing, checked
// against an in-bench window statistics calculation; depends on thws_pkg and the rtl
`timescale 1ns / 1ps

module tof_hit_window_statistics_test;

   localparam int HIT_DEPTH = 4096;
   localparam int BND_DEPTH = 256;
   localparam int TW  = thws_pkg::TOF_W;
   localparam int PLW = thws_pkg::PULSES_W;
   localparam int CNW = thws_pkg::OUT_CNT_W;
   localparam int QW  = thws_pkg::Q8_W;
   localparam int AW  = thws_pkg::CSR_AW;

   typedef struct packed {
      logic [CNW-1:0] pulses;
      logic [CNW-1:0] hits;
      logic [QW-1:0]  mean;
      logic [QW-1:0]  dev;
      logic [CNW-1:0] overlap;
      logic           ovf;
   } window_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready, req_last_hit = 1'b0;
   logic [TW-1:0] req_hit_tof = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [CNW-1:0] rsp_pulses_analyzed, rsp_total_hits, rsp_overlap_hits;
   logic [QW-1:0] rsp_mean_q8, rsp_deviation_q8;
   logic rsp_store_overflow;
   logic csr_we = 1'b0;
   logic [AW-1:0] csr_addr = '0;
   logic [TW-1:0] csr_wdata = '0;

   tof_hit_window_statistics dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // in-bench copy of the batch state and registers
   logic [TW-1:0]    win_ticks;
   logic [PLW-1:0]   pulses_cfg;
   logic [TW-1:0]    tof_mem [HIT_DEPTH];
   int unsigned      bnd_mem [BND_DEPTH];
   int unsigned      n_stored, n_bounds;
   logic [TW-1:0]    last_tof;
   logic             dropped;
   longint unsigned  s_cnt, s_sum, s_sq;

   window_stats_type expected_stats [$];
   int  err_count = 0, batch_count = 0, hit_count_tb = 0, stats_seen = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0, bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic void clear_batch();
      n_stored = 0; n_bounds = 1; bnd_mem[0] = 0; last_tof = '0;
      s_cnt = 0; s_sum = 0; s_sq = 0; dropped = 1'b0;
   endfunction

   // slide the window across one pulse and gather the hit counts
   function automatic void scan_pulse(int unsigned first, int unsigned stop);
      int unsigned quarter, w, c, w0;
      int unsigned w_end, target;
      longint unsigned cnt;
      quarter = win_ticks / 4;
      w = first;
      while (w + 1 < stop) begin
         w_end  = tof_mem[w] + win_ticks;
         target = tof_mem[w] + quarter;
         c = w; cnt = 0; w0 = w;
         while (c < stop && tof_mem[c] <= w_end) begin
            cnt++; c++;
         end
         if (cnt > 0) begin
            s_cnt++; s_sum += cnt; s_sq += cnt * cnt;
         end
         while (w < stop && tof_mem[w] < target) w++;
         if (w == w0 && w < stop) w++;
      end
   endfunction

   // take one accepted hit; on the last hit queue the expected statistics
   function automatic void add_hit(logic [TW-1:0] tof, logic last);
      window_stats_type r;
      longint unsigned mean, dev, ovl, n, nn, d, q, rm, k;
      int unsigned np, stop;
      if (n_stored < HIT_DEPTH) begin
         if (n_stored > 0 && tof < last_tof && last_tof - tof > thws_pkg::DROP_LIMIT) begin
            if (n_bounds < BND_DEPTH) bnd_mem[n_bounds] = n_stored;
            n_bounds++;
         end
         tof_mem[n_stored] = tof;
         n_stored++;
         last_tof = tof;
      end else begin
         dropped = 1'b1;
      end
      if (!last) return;
      dev = 0; ovl = 0;
      if (n_bounds < pulses_cfg) begin
         np = n_bounds;
         mean = (longint'(n_stored) * 256) / n_bounds;
      end else begin
         np = pulses_cfg;
         if (np > n_bounds) np = n_bounds;
         if (np >= BND_DEPTH) np = (n_bounds == BND_DEPTH) ? BND_DEPTH : BND_DEPTH - 1;
         for (int unsigned p = 0; p < np; p++) begin
            stop = (p + 1 < n_bounds) ? bnd_mem[p + 1] : n_stored;
            scan_pulse(bnd_mem[p], stop);
         end
         if (s_cnt == 0) begin
            mean = 256;
         end else begin
            n = s_cnt; nn = n * n;
            d = n * s_sq - s_sum * s_sum;
            q = d / nn; rm = d % nn;
            mean = (s_sum * 256) / n;
            dev = int_sqrt(q * 65536 + (rm * 65536) / nn);
            k = int_sqrt((9 * d) / nn);
            while (k * k * nn < 9 * d) k++;
            ovl = k;
         end
      end
      if (mean > thws_pkg::Q8_MAX) mean = thws_pkg::Q8_MAX;
      r.pulses = CNW'(np); r.hits = CNW'(n_stored); r.mean = QW'(mean); r.dev = QW'(dev);
      r.overlap = CNW'(ovl); r.ovf = dropped;
      expected_stats.insert(expected_stats.size(), r);
      batch_count++;
      clear_batch();
   endfunction

   // send one hit; valid stays high afterward until the next call or a pause
   task automatic send_hit(logic [TW-1:0] tof, logic last);
      int gap;
      gap = int'($urandom_range(0, 4));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_hit_tof <= tof;
      req_last_hit <= last;
      do @(posedge clock); while (!req_ready);
      add_hit(tof, last);
      hit_count_tb++;
      @(negedge clock);
   endtask

   // wait for all statistics to drain, then write one register
   task automatic write_reg(thws_pkg::csr_index_type idx, logic [TW-1:0] val);
      req_valid <= 1'b0;
      while (expected_stats.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == thws_pkg::CSR_WINDOW_TICKS) win_ticks = val;
      else pulses_cfg = val[PLW-1:0];
   endtask

   task automatic send_ascending(int len, int step, logic [TW-1:0] base);
      logic [TW-1:0] t = base;
      for (int i = 0; i < len; i++) begin
         send_hit(t, i == len - 1);
         t = (t > 20'hFFFFF - step) ? 20'hFFFFF : TW'(t + step);
      end
   endtask

   // result side stall pattern
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = int'($urandom_range(0, 4));
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
         err_count++;
      end
   endtask

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      window_stats_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_stats.size() == 0) begin
            $display("%0t unexpected result transfer, mean %0d", $time, rsp_mean_q8);
            err_count++;
         end else begin
            e = expected_stats.pop_front();
            check_field("pulses_analyzed", e.pulses, rsp_pulses_analyzed);
            check_field("total_hits", e.hits, rsp_total_hits);
            check_field("mean_q8", e.mean, rsp_mean_q8);
            check_field("deviation_q8", e.dev, rsp_deviation_q8);
            check_field("overlap_hits", e.overlap, rsp_overlap_hits);
            check_field("store_overflow", e.ovf, rsp_store_overflow);
            stats_seen++;
         end
      end
   end

   // register defaults, single hits and field extremes
   task automatic test_defaults();
      send_hit(20'd0, 1'b1);
      send_hit(20'hFFFFF, 1'b1);
      send_hit(20'd0, 1'b0);
      send_hit(20'hFFFFF, 1'b0);
      send_hit(20'd0, 1'b1);
      send_ascending(6, 900, 20'd100);
   endtask

   task automatic test_window_extremes();
      write_reg(thws_pkg::CSR_WINDOW_TICKS, 20'd0);
      send_ascending(5, 1, 20'd10);
      send_ascending(4, 0, 20'd7);
      write_reg(thws_pkg::CSR_WINDOW_TICKS, 20'hFFFFF);
      send_ascending(5, 200000, 20'd0);
      write_reg(thws_pkg::CSR_WINDOW_TICKS, 20'd3);
      send_ascending(6, 1, 20'hFFFFA);
   endtask

   // several pulses, fallback with too few boundaries, and zero pulses
   task automatic test_pulses();
      write_reg(thws_pkg::CSR_WINDOW_TICKS, 20'd4000);
      write_reg(thws_pkg::CSR_PULSES_WANTED, 20'd2);
      send_hit(20'd50000, 1'b0); send_hit(20'd51000, 1'b0);
      send_hit(20'd100, 1'b0);   send_hit(20'd1500, 1'b0);
      send_hit(20'd40000, 1'b0); send_hit(20'd30000, 1'b1);
      write_reg(thws_pkg::CSR_PULSES_WANTED, 20'd255);
      send_ascending(5, 500, 20'd0);
      write_reg(thws_pkg::CSR_PULSES_WANTED, 20'd0);
      send_ascending(4, 500, 20'd0);
   endtask

   // more boundaries than the boundary store holds
   task automatic test_boundary_full();
      write_reg(thws_pkg::CSR_PULSES_WANTED, 20'd255);
      write_reg(thws_pkg::CSR_WINDOW_TICKS, 20'd100);
      for (int i = 0; i < 540; i++)
         send_hit((i % 2 == 0) ? 20'd60000 : 20'd5, i == 539);
   endtask

   function automatic logic [TW-1:0] next_tof(logic [TW-1:0] prev);
      int unsigned r, v;
      r = $urandom_range(0, 99);
      if (r < 8) return TW'($urandom);
      if (r < 22 && prev > 20'd15000) return TW'($urandom_range(0, prev - 10001));
      v = prev + $urandom_range(0, (r < 60) ? 300 : 6000);
      return (v > 20'hFFFFF) ? 20'hFFFFF : TW'(v);
   endfunction

   // random batches, mostly well-formed rising runs with drops between pulses
   task automatic test_random(int n_items);
      int sent = 0, len, r;
      logic [TW-1:0] t;
      while (sent < n_items) begin
         if ($urandom_range(0, 3) == 0) begin
            r = int'($urandom_range(0, 9));
            write_reg(thws_pkg::CSR_WINDOW_TICKS, (r == 0) ? 20'hFFFFF : (r == 1) ? 20'd0 :
                      TW'($urandom_range(0, 20000)));
            r = int'($urandom_range(0, 9));
            write_reg(thws_pkg::CSR_PULSES_WANTED,
                      (r == 0) ? 20'd255 : TW'($urandom_range(0, 6)));
         end
         len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40))
                                            : int'($urandom_range(1, 12));
         t = TW'($urandom_range(0, 40000));
         for (int i = 0; i < len; i++) begin
            send_hit(t, i == len - 1);
            t = next_tof(t);
         end
         sent += len;
      end
   endtask

   initial begin
      int wait_cycles;
      win_ticks = thws_pkg::WINDOW_RESET;
      pulses_cfg = thws_pkg::PULSES_RESET;
      clear_batch();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_defaults();
      test_window_extremes();
      test_pulses();
      test_boundary_full();
      test_random(460);
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (expected_stats.size() != 0 && wait_cycles < 200000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (50) @(negedge clock);
      if (expected_stats.size() != 0) begin
         $display("%0t %0d expected results never arrived", $time, expected_stats.size());
         err_count++;
      end
      $display("covered %0d hits in %0d batches, %0d results compared, %0d mismatches",
               hit_count_tb, batch_count, stats_seen, err_count);
      if (err_count == 0)
         $display("[tof_hit_window_statistics] OK");
      else
         $display("[tof_hit_window_statistics] ERROR");
      $finish;
   end

   initial begin
      #10ms;
      $display("[tof_hit_window_statistics] ERROR");
      $finish;
   end

endmodule
